// File: sv/cpc_pkg.sv
//------------------------------------------------------------------------------
// cpc_pkg: shared types and constants for the command prefix completion block
// Holds the dictionary geometry, the transaction structs, the result codes
// and the small helper function used by the emitter.
//------------------------------------------------------------------------------
`default_nettype none

package cpc_pkg;

   localparam int ENTRIES     = 16;
   localparam int ENTRY_LEN   = 16;
   localparam int CHAR_W      = 8;
   localparam int IDX_W       = $clog2(ENTRIES);
   localparam int POS_W       = $clog2(ENTRY_LEN);
   localparam int PLEN_W      = $clog2(ENTRY_LEN + 2);
   localparam int COUNT_W     = $clog2(ENTRIES + 1);
   localparam int ROW_W       = ENTRIES * CHAR_W;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      KIND_NONE      = 2'd0,
      KIND_SUFFIX    = 2'd1,
      KIND_CANDIDATE = 2'd2
   } result_kind_type;

   typedef struct packed {
      logic              req_type;
      logic [3:0]        entry_index;
      logic [3:0]        char_position;
      logic [CHAR_W-1:0] char_value;
      logic              prefix_end;
   } req_data_type;

   typedef struct packed {
      result_kind_type   result_kind;
      logic [4:0]        match_count;
      logic [CHAR_W-1:0] suffix_char;
      logic [3:0]        candidate_index;
      logic              last_result;
   } rsp_data_type;

   typedef struct packed {
      logic              en;
      logic [POS_W-1:0]  row;
      logic [IDX_W-1:0]  lane;
      logic [CHAR_W-1:0] data;
   } store_wr_type;

   typedef struct packed {
      logic [ENTRIES-1:0] mask;
      logic [COUNT_W-1:0] count;
      logic [PLEN_W-1:0]  plen;
   } job_type;

   typedef struct packed {
      logic not_empty;
      logic full;
      logic has_suffix;
   } queue_status_type;

   typedef enum logic [1:0] {
      S1_IDLE,
      S1_CHAR,
      S1_END
   } stage_op_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_NONE,
      BACK_SUFFIX,
      BACK_LIST
   } back_state_type;

   // Index of the highest set bit; zero when the mask is empty.
   function automatic logic [IDX_W-1:0] highest_set(input logic [ENTRIES-1:0] mask);
      logic [IDX_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (mask[i]) begin
            idx = IDX_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

`default_nettype wire

// File: sv/cpc_store.sv
//------------------------------------------------------------------------------
// cpc_store: dictionary memory
// One row per character position, one byte lane per entry. Byte writes,
// two registered read ports, and a clearing pass of one row per cycle
// after reset.
//------------------------------------------------------------------------------
`default_nettype none

module cpc_store
   import cpc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire store_wr_type      wr,
   input  wire logic [POS_W-1:0]  rd_a_addr,
   output logic      [ROW_W-1:0]  rd_a_data,
   input  wire logic [POS_W-1:0]  rd_b_addr,
   output logic      [ROW_W-1:0]  rd_b_data,
   output logic                   clearing
);

   logic [ROW_W-1:0] store_mem [ENTRY_LEN];
   logic [POS_W:0]   clr_ff;
   logic [POS_W:0]   clr_in;
   logic [ROW_W-1:0] rd_a_data_ff;
   logic [ROW_W-1:0] rd_b_data_ff;

   // The counter stops once its top bit is set, which is after every row.
   assign clearing = ~clr_ff[POS_W];
   assign clr_in   = clearing ? clr_ff + (POS_W+1)'(1) : clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing) begin
         store_mem[clr_ff[POS_W-1:0]] <= '0;
      end else if (wr.en) begin
         store_mem[wr.row][wr.lane*CHAR_W +: CHAR_W] <= wr.data;
      end
      rd_a_data_ff <= store_mem[rd_a_addr];
      rd_b_data_ff <= store_mem[rd_b_addr];
   end

   assign rd_a_data = rd_a_data_ff;
   assign rd_b_data = rd_b_data_ff;

endmodule

`default_nettype wire

// File: sv/cpc_front.sv
//------------------------------------------------------------------------------
// cpc_front: request decoder and prefix matcher
// Routes writes to the store, narrows the match mask one prefix character
// per accepted cycle, and turns an end request into a job for the emitter.
//------------------------------------------------------------------------------
`default_nettype none

module cpc_front
   import cpc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire req_data_type      req,
   output store_wr_type           wr,
   output logic      [POS_W-1:0]  rd_addr,
   input  wire logic [ROW_W-1:0]  rd_data,
   output logic                   push,
   output job_type                job,
   output logic                   end_pending
);

   function automatic logic [COUNT_W-1:0] popcount(input logic [ENTRIES-1:0] mask);
      logic [COUNT_W-1:0] cnt;
      cnt = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         cnt = cnt + COUNT_W'(mask[i]);
      end
      return cnt;
   endfunction

   logic               accept_char;
   logic               accept_end;
   logic [PLEN_W-1:0]  plen_ff, plen_in;
   logic [ENTRIES-1:0] mask_ff, mask_in;
   stage_op_type       s1_op_ff, s1_op_in;
   logic [CHAR_W-1:0]  s1_char_ff;
   logic               s1_over_ff;
   logic [PLEN_W-1:0]  s1_plen_ff;
   logic [ENTRIES-1:0] eq_vec;

   assign accept_char = accept && (req.req_type == REQ_QUERY) && !req.prefix_end &&
                        (req.char_value != '0);
   assign accept_end  = accept && (req.req_type == REQ_QUERY) && req.prefix_end;

   always_comb begin
      wr.en   = accept && (req.req_type == REQ_WRITE);
      wr.row  = req.char_position;
      wr.lane = req.entry_index;
      wr.data = req.char_value;
   end

   // The row at the current prefix position is read as the character arrives.
   assign rd_addr = plen_ff[POS_W-1:0];

   always_comb begin
      s1_op_in = S1_IDLE;
      plen_in  = plen_ff;
      if (accept_char) begin
         s1_op_in = S1_CHAR;
         if (plen_ff <= PLEN_W'(ENTRY_LEN)) begin
            plen_in = plen_ff + PLEN_W'(1);
         end
      end else if (accept_end) begin
         s1_op_in = S1_END;
         plen_in  = '0;
      end
   end

   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         eq_vec[i] = (rd_data[i*CHAR_W +: CHAR_W] == s1_char_ff);
      end
   end

   always_comb begin
      mask_in = mask_ff;
      case (s1_op_ff)
         S1_CHAR: begin
            mask_in = s1_over_ff ? '0 : (mask_ff & eq_vec);
         end
         S1_END: begin
            mask_in = '1;
         end
         default: begin
            mask_in = mask_ff;
         end
      endcase
   end

   assign push        = (s1_op_ff == S1_END);
   assign end_pending = (s1_op_ff == S1_END);

   always_comb begin
      job.mask  = mask_ff;
      job.count = popcount(mask_ff);
      job.plen  = s1_plen_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff  <= '0;
         mask_ff  <= '1;
         s1_op_ff <= S1_IDLE;
      end else begin
         plen_ff  <= plen_in;
         mask_ff  <= mask_in;
         s1_op_ff <= s1_op_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_char_ff <= req.char_value;
      s1_over_ff <= (plen_ff >= PLEN_W'(ENTRY_LEN));
      s1_plen_ff <= plen_ff;
   end

endmodule

`default_nettype wire

// File: sv/cpc_queue.sv
//------------------------------------------------------------------------------
// cpc_queue: job queue between matcher and emitter
// A two-entry FIFO of finished queries. It also reports whether any held
// job will stream a suffix, since such a job still has to read the store.
//------------------------------------------------------------------------------
`default_nettype none

module cpc_queue
   import cpc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire job_type  push_job,
   input  wire logic     pop,
   output job_type       head,
   output queue_status_type status
);

   job_type                  q_mem [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]   valid_ff, valid_in;
   logic [QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic                     suffix_any;

   always_comb begin
      valid_in  = valid_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         valid_in[rd_ptr_ff] = 1'b0;
         rd_ptr_in           = rd_ptr_ff + QPTR_W'(1);
      end
      if (push) begin
         valid_in[wr_ptr_ff] = 1'b1;
         wr_ptr_in           = wr_ptr_ff + QPTR_W'(1);
      end
   end

   always_comb begin
      suffix_any = 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (valid_ff[i] && (q_mem[i].count == COUNT_W'(1))) begin
            suffix_any = 1'b1;
         end
      end
   end

   assign head              = q_mem[rd_ptr_ff];
   assign status.not_empty  = valid_ff[rd_ptr_ff];
   assign status.full       = valid_ff[wr_ptr_ff];
   assign status.has_suffix = suffix_any;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// File: sv/cpc_back.sv
//------------------------------------------------------------------------------
// cpc_back: result emitter
// Takes one job at a time and emits its results one per cycle: a single
// no-match result, the suffix characters of the only match, or the list
// of matching entries from the highest index down.
//------------------------------------------------------------------------------
`default_nettype none

module cpc_back
   import cpc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire job_type           head,
   input  wire logic              head_valid,
   output logic                   pop,
   output logic      [POS_W-1:0]  rd_addr,
   input  wire logic [ROW_W-1:0]  rd_data,
   output logic                   in_suffix,
   output logic                   rsp_valid,
   output rsp_data_type           rsp_data
);

   back_state_type     state_ff, state_in;
   logic [ENTRIES-1:0] mask_ff, mask_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [PLEN_W-1:0]  pos_ff, pos_in;
   logic               dv_ff, dv_in;
   logic               term_ff, term_in;
   logic               have_prev_ff, have_prev_in;
   logic [CHAR_W-1:0]  prev_ff, prev_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_data_type       rsp_data_ff, rsp_data_in;

   logic [IDX_W-1:0]   top_idx;
   logic [ENTRIES-1:0] rest_mask;
   logic [CHAR_W-1:0]  cur_char;

   assign top_idx   = highest_set(mask_ff);
   assign rest_mask = mask_ff & ~(ENTRIES'(1) << top_idx);
   // A read past the last position acts as the terminator.
   assign cur_char  = term_ff ? '0 : rd_data[top_idx*CHAR_W +: CHAR_W];
   assign rd_addr   = pos_ff[POS_W-1:0];
   assign in_suffix = (state_ff == BACK_SUFFIX);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (head_valid) begin
               if (head.count == '0) begin
                  state_in = BACK_NONE;
               end else if (head.count == COUNT_W'(1)) begin
                  state_in = BACK_SUFFIX;
               end else begin
                  state_in = BACK_LIST;
               end
            end
         end
         BACK_NONE: begin
            state_in = BACK_IDLE;
         end
         BACK_SUFFIX: begin
            if (dv_ff && (cur_char == '0)) begin
               state_in = BACK_IDLE;
            end
         end
         BACK_LIST: begin
            if (rest_mask == '0) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   // Outputs and datapath.
   always_comb begin
      pop          = 1'b0;
      mask_in      = mask_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      dv_in        = dv_ff;
      term_in      = term_ff;
      have_prev_in = have_prev_ff;
      prev_in      = prev_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      case (state_ff)
         BACK_IDLE: begin
            if (head_valid) begin
               pop          = 1'b1;
               mask_in      = head.mask;
               count_in     = head.count;
               pos_in       = head.plen;
               dv_in        = 1'b0;
               have_prev_in = 1'b0;
            end
         end
         BACK_NONE: begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.result_kind  = KIND_NONE;
            rsp_data_in.last_result  = 1'b1;
         end
         BACK_SUFFIX: begin
            // Each character is held back in prev_ff so that the next read
            // tells whether it is the last one.
            pos_in  = pos_ff + PLEN_W'(1);
            dv_in   = 1'b1;
            term_in = (pos_ff >= PLEN_W'(ENTRY_LEN));
            if (dv_ff) begin
               if (cur_char == '0) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.last_result = 1'b1;
                  if (have_prev_ff) begin
                     rsp_data_in.result_kind = KIND_SUFFIX;
                     rsp_data_in.match_count = 5'(1);
                     rsp_data_in.suffix_char = prev_ff;
                  end else begin
                     rsp_data_in.result_kind = KIND_NONE;
                  end
               end else begin
                  if (have_prev_ff) begin
                     rsp_valid_in            = 1'b1;
                     rsp_data_in.result_kind = KIND_SUFFIX;
                     rsp_data_in.match_count = 5'(1);
                     rsp_data_in.suffix_char = prev_ff;
                  end
                  prev_in      = cur_char;
                  have_prev_in = 1'b1;
               end
            end
         end
         BACK_LIST: begin
            rsp_valid_in                = 1'b1;
            rsp_data_in.result_kind     = KIND_CANDIDATE;
            rsp_data_in.match_count     = 5'(count_ff);
            rsp_data_in.candidate_index = 4'(top_idx);
            rsp_data_in.last_result     = (rest_mask == '0);
            mask_in                     = rest_mask;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff      <= mask_in;
      count_ff     <= count_in;
      pos_ff       <= pos_in;
      dv_ff        <= dv_in;
      term_ff      <= term_in;
      have_prev_ff <= have_prev_in;
      prev_ff      <= prev_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: sv/command_prefix_completion.sv
//------------------------------------------------------------------------------
// command_prefix_completion: prefix-match autocompletion over a dictionary
// Sixteen command strings of up to sixteen characters are loaded by write
// transactions; query transactions narrow a match mask one character at a
// time, and an end transaction reports no match, the completion suffix, or
// the list of candidate entries.
//
//   Channel   Ports                      Handshake
//   request   start, busy, req_data      taken when start is high, busy low
//   response  rsp_valid, rsp_data        one cycle per result, never stalled
//
// Write and prefix-character transactions can be issued back to back. An
// end transaction spends the cycle after it is taken in the matcher stage
// and is written into the queue at the next edge. The idle emitter then
// pops the job and enters its no-match, suffix or list state; each result
// is registered before it reaches the ports, and a suffix first reads the
// store ahead of its first character. Within one query the results then
// follow one per cycle, up to sixteen, and the emitter passes through its
// idle state between queries.
// While a suffix is streaming (or queued) busy stays high, because the
// suffix must read the store as it stood at the end transaction. Candidate
// lists and no-match results run in the background behind the two-entry
// queue; busy is high in the cycle after each end transaction and
// otherwise only when that queue is full.
// After reset the store is cleared one row per cycle, so busy stays high
// until every row is cleared. The response side has no back-pressure.
//------------------------------------------------------------------------------
`default_nettype none

module command_prefix_completion
   import cpc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire req_data_type req_data,
   output logic              rsp_valid,
   output rsp_data_type      rsp_data
);

   logic             accept;
   logic             clearing;
   store_wr_type     store_wr;
   logic [POS_W-1:0] match_rd_addr;
   logic [ROW_W-1:0] match_rd_data;
   logic [POS_W-1:0] emit_rd_addr;
   logic [ROW_W-1:0] emit_rd_data;
   logic             job_push;
   job_type          job_new;
   logic             end_pending;
   logic             job_pop;
   job_type          job_head;
   queue_status_type q_status;
   logic             in_suffix;

   // An end transaction waits in the matcher stage before it is queued, so
   // busy covers that time too; otherwise a following write could slip
   // in ahead of a suffix read.
   assign busy   = clearing || q_status.full || end_pending ||
                   q_status.has_suffix || in_suffix;
   assign accept = start && !busy;

   cpc_store u_store (
      .clock     (clock),
      .reset     (reset),
      .wr        (store_wr),
      .rd_a_addr (match_rd_addr),
      .rd_a_data (match_rd_data),
      .rd_b_addr (emit_rd_addr),
      .rd_b_data (emit_rd_data),
      .clearing  (clearing)
   );

   cpc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .req         (req_data),
      .wr          (store_wr),
      .rd_addr     (match_rd_addr),
      .rd_data     (match_rd_data),
      .push        (job_push),
      .job         (job_new),
      .end_pending (end_pending)
   );

   cpc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job_new),
      .pop      (job_pop),
      .head     (job_head),
      .status   (q_status)
   );

   cpc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (job_head),
      .head_valid (q_status.not_empty),
      .pop        (job_pop),
      .rd_addr    (emit_rd_addr),
      .rd_data    (emit_rd_data),
      .in_suffix  (in_suffix),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// File: sim/cpc_checker.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// cpc_checker: result checker for the command prefix completion block
// Watches both channels, keeps its own copy of the dictionary and the
// prefix matcher, and compares every result against the oldest expected one.
//------------------------------------------------------------------------------

module cpc_checker
   import cpc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic         busy,
   input  wire req_data_type req_data,
   input  wire logic         rsp_valid,
   input  wire rsp_data_type rsp_data,
   output int                error_count,
   output int                pending,
   output int                checked
);

   logic [CHAR_W-1:0]  dict_chars [ENTRIES][ENTRY_LEN];
   logic [ENTRIES-1:0] live_mask;
   int                 prefix_len;
   rsp_data_type       completions_due[$];

   task automatic report_field(input string name, input logic [7:0] want, input logic [7:0] got);
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      error_count++;
   endtask

   task automatic compare_result(input rsp_data_type got);
      rsp_data_type want;
      if (completions_due.size() == 0) begin
         $display("%0t: unexpected result, expected none actual %0h", $time, got);
         error_count++;
      end else begin
         want = completions_due.pop_front();
         checked++;
         if (want.result_kind != got.result_kind)
            report_field("result_kind", 8'(want.result_kind), 8'(got.result_kind));
         if (want.match_count != got.match_count)
            report_field("match_count", 8'(want.match_count), 8'(got.match_count));
         if (want.suffix_char != got.suffix_char)
            report_field("suffix_char", want.suffix_char, got.suffix_char);
         if (want.candidate_index != got.candidate_index)
            report_field("candidate_index", 8'(want.candidate_index), 8'(got.candidate_index));
         if (want.last_result != got.last_result)
            report_field("last_result", 8'(want.last_result), 8'(got.last_result));
      end
   endtask

   // Updates the matcher state for one transaction and queues the results
   // that an end transaction produces.
   task automatic predict_completion(input req_data_type t);
      rsp_data_type r;
      int           count;
      int           only;
      int           n;
      n = 0;
      if (t.req_type == REQ_WRITE) begin
         if (int'(t.entry_index) < ENTRIES && int'(t.char_position) < ENTRY_LEN)
            dict_chars[t.entry_index][t.char_position] = t.char_value;
      end else if (!t.prefix_end) begin
         if (t.char_value != '0) begin
            if (prefix_len >= ENTRY_LEN) begin
               live_mask = '0;
            end else begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (dict_chars[i][prefix_len] != t.char_value)
                     live_mask[i] = 1'b0;
               end
            end
            if (prefix_len <= ENTRY_LEN)
               prefix_len++;
         end
      end else begin
         count = 0;
         only  = 0;
         for (int i = 0; i < ENTRIES; i++) begin
            if (live_mask[i]) begin
               count++;
               only = i;
            end
         end
         if (count == 1) begin
            for (int p = prefix_len; p < ENTRY_LEN && n < 16; p++) begin
               if (dict_chars[only][p] == '0)
                  break;
               r = '0;
               r.result_kind = KIND_SUFFIX;
               r.match_count = 5'd1;
               r.suffix_char = dict_chars[only][p];
               completions_due.push_back(r);
               n++;
            end
         end else if (count > 1) begin
            for (int i = ENTRIES - 1; i >= 0 && n < 16; i--) begin
               if (live_mask[i]) begin
                  r = '0;
                  r.result_kind     = KIND_CANDIDATE;
                  r.match_count     = 5'(count);
                  r.candidate_index = 4'(i);
                  completions_due.push_back(r);
                  n++;
               end
            end
         end
         if (n == 0) begin
            r = '0;
            r.result_kind = KIND_NONE;
            completions_due.push_back(r);
         end
         r = completions_due.pop_back();
         r.last_result = 1'b1;
         completions_due.push_back(r);
         live_mask  = '1;
         prefix_len = 0;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++)
            for (int p = 0; p < ENTRY_LEN; p++)
               dict_chars[i][p] = '0;
         live_mask   = '1;
         prefix_len  = 0;
         completions_due.delete();
         error_count = 0;
         checked     = 0;
      end else begin
         if (rsp_valid)
            compare_result(rsp_data);
         if (start && !busy)
            predict_completion(req_data);
      end
      pending = completions_due.size();
   end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb: testbench top for the command prefix completion block
// Drives write and query transactions, directed first and then random, under
// several sender idle patterns; the checker beside the block predicts and
// compares every result and reports its failure count here.
//------------------------------------------------------------------------------

module tb;
   import cpc_pkg::*;

   // Random transactions to send after the directed part.
   localparam int RANDOM_ITEMS = 350;
   // Generous cycle limit: every end transaction may emit sixteen results and
   // the sender may sit idle for long stretches in the idle-heavy phase.
   localparam int CYCLE_LIMIT  = 300000;
   // Cycles to keep watching after the last expected result, so that a stray
   // extra result would still be seen.
   localparam int DRAIN_CYCLES = 40;

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_data_type req_data;
   logic         rsp_valid;
   rsp_data_type rsp_data;

   int error_count;
   int pending;
   int checked;

   int cycles;
   int items;
   int ends;
   int idle_pct;

   // Stimulus-side copy of what has been written, used only to shape queries
   // so that prefixes actually hit stored entries.
   logic [7:0] shadow [ENTRIES][ENTRY_LEN];

   command_prefix_completion u_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data)
   );

   cpc_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .error_count(error_count),
      .pending    (pending),
      .checked    (checked)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake or a missing result ends the run here.
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // Sender idle percentage for each quarter of the random part. The block
   // cannot stall its results, so the phases differ only on the request side;
   // the third phase stands for the one where only the receiver would stall.
   function automatic int idle_for_phase(input int phase);
      case (phase)
         1:       return 79;
         3:       return 32;
         default: return 0;
      endcase
   endfunction

   // Mostly a small alphabet so that entries share prefixes, with the full
   // nonzero range mixed in.
   function automatic logic [7:0] pick_char();
      if ($urandom_range(99) < 85)
         return 8'h61 + 8'($urandom_range(3));
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic int entry_length(input int e);
      for (int p = 0; p < ENTRY_LEN; p++) begin
         if (shadow[e][p] == 8'h00)
            return p;
      end
      return ENTRY_LEN;
   endfunction

   // One transaction: an optional idle gap, then start is held until the
   // block takes it at a rising edge with busy low. Every change happens at
   // a falling edge, so the block and the checker see stable inputs.
   task automatic send(input req_data_type t);
      logic [31:0] junk;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         junk = $urandom();
         start    <= 1'b0;
         req_data <= junk[$bits(req_data_type)-1:0];
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (busy);
      items++;
   endtask

   // Unused fields of each transaction carry random values so that they are
   // shown to be ignored.
   task automatic send_write(input int e, input int p, input logic [7:0] c);
      req_data_type t;
      t.req_type      = REQ_WRITE;
      t.entry_index   = 4'(e);
      t.char_position = 4'(p);
      t.char_value    = c;
      t.prefix_end    = 1'($urandom_range(1));
      shadow[e][p]    = c;
      send(t);
   endtask

   task automatic send_char(input logic [7:0] c);
      req_data_type t;
      t.req_type      = REQ_QUERY;
      t.entry_index   = 4'($urandom_range(15));
      t.char_position = 4'($urandom_range(15));
      t.char_value    = c;
      t.prefix_end    = 1'b0;
      send(t);
   endtask

   task automatic send_end();
      req_data_type t;
      t.req_type      = REQ_QUERY;
      t.entry_index   = 4'($urandom_range(15));
      t.char_position = 4'($urandom_range(15));
      t.char_value    = 8'($urandom_range(255));
      t.prefix_end    = 1'b1;
      ends++;
      send(t);
   endtask

   // Loads one whole entry: usually short, sometimes full length with no
   // terminator, sometimes empty.
   task automatic load_entry();
      int e;
      int len;
      int r;
      e = $urandom_range(ENTRIES - 1);
      r = $urandom_range(99);
      if (r < 10)
         len = ENTRY_LEN;
      else if (r < 15)
         len = 0;
      else
         len = $urandom_range(1, 5);
      for (int p = 0; p < len; p++)
         send_write(e, p, pick_char());
      if (len < ENTRY_LEN)
         send_write(e, len, 8'h00);
   endtask

   // A query built from a stored entry, so most prefixes match something.
   // Now and then the last character is changed, the prefix runs past the
   // entry length, an ignored zero character slips in, or a write lands in
   // the middle of the query.
   task automatic run_query();
      int         e;
      int         plen;
      logic [7:0] c;
      e = $urandom_range(ENTRIES - 1);
      if ($urandom_range(9) == 0)
         plen = ENTRY_LEN + $urandom_range(2);
      else
         plen = $urandom_range(0, entry_length(e));
      for (int p = 0; p < plen; p++) begin
         c = pick_char();
         if (p < ENTRY_LEN && shadow[e][p] != 8'h00)
            c = shadow[e][p];
         if (p == plen - 1 && $urandom_range(9) == 0)
            c = pick_char();
         if ($urandom_range(19) == 0)
            send_char(8'h00);
         if ($urandom_range(19) == 0)
            send_write($urandom_range(ENTRIES - 1), $urandom_range(ENTRY_LEN - 1), pick_char());
         send_char(c);
      end
      send_end();
   endtask

   // A fully random transaction.
   task automatic send_noise();
      logic [31:0]  junk;
      req_data_type t;
      junk = $urandom();
      t    = junk[$bits(req_data_type)-1:0];
      if (t.req_type == REQ_WRITE)
         shadow[t.entry_index][t.char_position] = t.char_value;
      if (t.req_type == REQ_QUERY && t.prefix_end)
         ends++;
      send(t);
   endtask

   initial begin
      int r;
      int random_start;
      for (int i = 0; i < ENTRIES; i++)
         for (int p = 0; p < ENTRY_LEN; p++)
            shadow[i][p] = 8'h00;
      items    = 0;
      ends     = 0;
      idle_pct = 0;
      reset    = 1'b1;
      start    = 1'b0;
      req_data = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, back to back. With the store still empty every entry
      // matches the empty prefix, so the first end lists all sixteen.
      send_end();
      // Entry 15 becomes "x" with a stray 0xff at the last position, beyond
      // its terminator.
      send_write(15, 0, 8'h78);
      send_write(15, ENTRY_LEN - 1, 8'hff);
      // A single match whose suffix is empty.
      send_char(8'h78);
      send_end();
      // Now entry 15 is "xy", so the same prefix completes with "y".
      send_write(15, 1, 8'h79);
      send_char(8'h78);
      send_end();
      // The top character value matches nothing.
      send_char(8'hff);
      send_end();
      // A zero prefix character is ignored.
      send_char(8'h78);
      send_char(8'h00);
      send_end();
      // Writes during a query: the suffix reads the new character, and a
      // change at a position already matched does not drop the entry.
      send_char(8'h78);
      send_write(15, 1, 8'h7a);
      send_write(15, 0, 8'h77);
      send_end();
      // Two entries share the prefix: candidates come highest index first.
      send_write(15, 0, 8'h78);
      send_write(3, 0, 8'h78);
      send_char(8'h78);
      send_end();

      // Random part, split into idle phases by progress.
      random_start = items;
      while (items - random_start < RANDOM_ITEMS) begin
         idle_pct = idle_for_phase(((items - random_start) * 4) / RANDOM_ITEMS);
         r = $urandom_range(99);
         if (r < 25)
            load_entry();
         else if (r < 85)
            run_query();
         else
            send_noise();
      end

      @(negedge clock);
      start <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("tb: %0d transactions sent, %0d of them prefix ends", items, ends);
      $display("tb: %0d results compared in %0d cycles", checked, cycles);
      if (error_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

// File: filelist.f
sv/cpc_pkg.sv
sv/cpc_store.sv
sv/cpc_front.sv
sv/cpc_queue.sv
sv/cpc_back.sv
sv/command_prefix_completion.sv
sim/cpc_checker.sv
sim/tb.sv
